FILE: hw/rtl/pbip_pkg.sv
// Package for the printer bit-image parser: byte codes, parser states and
// the result record shared by the parser core and the top level.
// No dependencies.
package pbip_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] CMD_L_BYTE = 8'h4c;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LINE_W = 16;
  localparam int unsigned COL_W  = 16;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ESC  = 5'b00010,
    ST_WLO  = 5'b00100,
    ST_WHI  = 5'b01000,
    ST_DATA = 5'b10000
  } pbip_state_t;

  typedef enum logic {
    KIND_TEXT  = 1'b0,
    KIND_PIXEL = 1'b1
  } pbip_kind_t;

  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [BYTE_W-1:0]  byte_out;
    logic [LINE_W-1:0]  line_number;
    logic [COL_W-1:0]   column;
  } pbip_res_t;

endpackage

FILE: hw/rtl/pbip_if.sv
// Request and result channel interfaces for the printer bit-image parser.
// Depends on pbip_pkg for the field widths.
interface pbip_in_if import pbip_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface pbip_out_if import pbip_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] byte_out;
  logic [LINE_W-1:0] line_number;
  logic [COL_W-1:0]  column;

  modport source (output valid, output kind, output byte_out, output line_number,
                  output column, input ready);
  modport sink   (input valid, input kind, input byte_out, input line_number,
                  input column, output ready);
endinterface

FILE: hw/rtl/pbip_parser.sv
// Parser core: ESC 'L' command state machine, sticky line width, pixel and
// line counters. Produces at most one result per request. Depends on pbip_pkg.
module pbip_parser import pbip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              gfx_mode,
  input  logic [BYTE_W-1:0] data_byte,
  output pbip_res_t         res
);

  pbip_state_t       state_r, state_nxt;
  logic [BYTE_W-1:0] wlo_r, wlo_nxt;
  logic [COL_W-1:0]  line_width_r, line_width_nxt;
  logic [COL_W-1:0]  pix_cnt_r, pix_cnt_nxt;
  logic [LINE_W-1:0] lines_seen_r, lines_seen_nxt;

  always_comb begin
    state_nxt       = state_r;
    wlo_nxt         = wlo_r;
    line_width_nxt  = line_width_r;
    pix_cnt_nxt     = pix_cnt_r;
    lines_seen_nxt  = lines_seen_r;
    res.valid       = 1'b0;
    res.kind        = KIND_TEXT;
    res.byte_out    = data_byte;
    res.line_number = '0;
    res.column      = '0;
    if (!gfx_mode) begin
      res.valid = 1'b1;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (data_byte == ESC_BYTE) state_nxt = ST_ESC;
        end
        ST_ESC: begin
          if (data_byte == CMD_L_BYTE) state_nxt = ST_WLO;
        end
        ST_WLO: begin
          wlo_nxt   = data_byte;
          state_nxt = ST_WHI;
        end
        ST_WHI: begin
          if (line_width_r == '0) line_width_nxt = {data_byte, wlo_r};
          pix_cnt_nxt = '0;
          if (lines_seen_r != '1) lines_seen_nxt = lines_seen_r + 1'b1;
          state_nxt = ST_DATA;
        end
        ST_DATA: begin
          if (pix_cnt_r < line_width_r) begin
            res.valid       = 1'b1;
            res.kind        = KIND_PIXEL;
            res.line_number = lines_seen_r - 1'b1;
            res.column      = pix_cnt_r;
            pix_cnt_nxt     = pix_cnt_r + 1'b1;
          end else begin
            state_nxt = (data_byte == ESC_BYTE) ? ST_ESC : ST_IDLE;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wlo_r        <= '0;
      line_width_r <= '0;
      pix_cnt_r    <= '1;
      lines_seen_r <= '0;
    end else if (step) begin
      state_r      <= state_nxt;
      wlo_r        <= wlo_nxt;
      line_width_r <= line_width_nxt;
      pix_cnt_r    <= pix_cnt_nxt;
      lines_seen_r <= lines_seen_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pix_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DATA |-> pix_cnt_r <= line_width_r)
    else $error("pixel count passed the line width");

  a_width_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    line_width_r != '0 |=> line_width_r == $past(line_width_r))
    else $error("captured line width changed");

  a_lines_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> lines_seen_r >= $past(lines_seen_r))
    else $error("line count went backward");
`endif

endmodule

FILE: hw/rtl/printer_bit_image_parser_unit.sv
// Top level of the printer bit-image parser: input register, parser core and
// result register. An accepted request passes the input register and then the
// result register. Throughput is one request per cycle unless out_ch stalls.
// Reset is synchronous and active low; it clears the mode register, the parser
// state and both pipeline valid flags. Depends on pbip_pkg and pbip_if.
module printer_bit_image_parser_unit import pbip_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  pbip_in_if.sink       in_ch,
  pbip_out_if.source    out_ch
);

  logic              gfx_mode_r;
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  pbip_res_t         out_r;
  pbip_res_t         res;
  logic              out_free;
  logic              adv;

  assign out_free     = !out_r.valid || out_ch.ready;
  assign adv          = in_vld_r && out_free;
  assign in_ch.ready  = !in_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gfx_mode_r <= 1'b0;
    end else if (cfg_we) begin
      gfx_mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_byte_r <= in_ch.data_byte;
  end

  pbip_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .gfx_mode  (gfx_mode_r),
    .data_byte (in_byte_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (adv) begin
      out_r.valid <= res.valid;
    end else if (out_ch.ready) begin
      out_r.valid <= 1'b0;
    end
    if (adv && res.valid) begin
      out_r.kind        <= res.kind;
      out_r.byte_out    <= res.byte_out;
      out_r.line_number <= res.line_number;
      out_r.column      <= res.column;
    end
  end

  assign out_ch.valid       = out_r.valid;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.byte_out    = out_r.byte_out;
  assign out_ch.line_number = out_r.line_number;
  assign out_ch.column      = out_r.column;

`ifndef ASSERT_OFF
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r)
    else $error("buffered request dropped while stalled");

  a_text_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !gfx_mode_r |=> out_r.valid && out_r.kind == KIND_TEXT)
    else $error("text byte did not produce a text result");

  a_text_tags: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && out_r.kind == KIND_TEXT |-> out_r.line_number == '0 && out_r.column == '0)
    else $error("text result carries line or column");
`endif

endmodule
